[src/slt_pkg.sv]
`timescale 1ns / 1ps
package slt_pkg;

   localparam int VALUE_W      = 32;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 3;
   localparam int POS_W        = 6;
   localparam int DEF_CAPACITY = 32;

   // Packed widths of the stream payloads, rounded up to whole bytes.
   localparam int REQ_BITS   = CMD_W + VALUE_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = STATUS_W + 2 * POS_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;

   // Shift command broadcast to every cell of the chain.
   typedef struct packed {
      logic ins;   // open a slot at the insert point, shift the tail right
      logic del;   // close the slot of the first match, shift the tail left
   } slt_op_type;

endpackage

[src/sorted_list_table.sv]
`timescale 1ns / 1ps
// Sorted list table: keeps up to CAPACITY signed 32-bit values in ascending
// order and runs one command per item on the request stream.
// The request channel carries a command (insert, delete, find) and a value.
// Insert places the value ahead of any equal entries and is refused when the
// list is full. Delete removes the first equal entry. Find reports the
// 1-based position of the first equal entry. Each request yields exactly one
// response item with a status, a position and the occupancy after the command.
// A taken item is held in the request register and executes once the output
// register is free; on execution every cell of the compare-and-shift chain
// compares its entry with the key and loads its new entry from itself, a
// neighbor or the key. The response is registered. No new item is taken
// while one is held, a limit set by the take-then-execute step of the chain.
// Reset empties the list at once; stored values need no clearing because a
// cell beyond the occupancy is never looked at.
// When the receiver stalls, the response holds in its output register, one
// further request is still taken, and that one waits to execute until the
// output register is free.
module sorted_list_table
   import slt_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] command, [33:2] value, upper bits zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] status, [8:3] position, [14:9] occupancy, upper bits zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Request holding register.
   logic               busy_ff, busy_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [VALUE_W-1:0] key_ff, key_in;

   // List occupancy.
   logic [CNT_W-1:0]   count_ff, count_in;

   // Response output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    occ_ff, occ_in;

   logic req_accept;
   logic exec;
   logic is_full;
   logic found;
   logic [CNT_W-1:0] match_pos;
   slt_op_type op;

   logic [VALUE_W-1:0] entry_w [CAPACITY];
   logic [CAPACITY-1:0] valid_w;
   logic [CAPACITY-1:0] lt_w;
   logic [CAPACITY-1:0] first_w;

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;
   // The held item executes once the output register can take its response.
   assign exec       = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign found      = |first_w;

   assign op.ins = exec && (cmd_ff == CMD_INSERT) && !is_full;
   assign op.del = exec && (cmd_ff == CMD_DELETE) && found;

   // A cell holds a live entry when its place is below the occupancy.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid_w[i] = (CNT_W'(i) < count_ff);
      end
   end

   // Only one cell can flag the first match, so the position is an OR.
   always_comb begin
      match_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_w[i]) begin
            match_pos = match_pos | CNT_W'(i + 1);
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic               left_lt_w;
         logic [VALUE_W-1:0] left_entry_w;
         logic [VALUE_W-1:0] right_entry_w;

         if (g == 0) begin : g_head
            assign left_lt_w    = 1'b1;
            assign left_entry_w = key_ff;
         end else begin : g_body
            assign left_lt_w    = lt_w[g-1];
            assign left_entry_w = entry_w[g-1];
         end

         if (g == CAPACITY - 1) begin : g_tail
            assign right_entry_w = key_ff;
         end else begin : g_inner
            assign right_entry_w = entry_w[g+1];
         end

         slt_cell u_cell (
            .clock       (clock),
            .op          (op),
            .key         (key_ff),
            .valid       (valid_w[g]),
            .left_lt     (left_lt_w),
            .left_entry  (left_entry_w),
            .right_entry (right_entry_w),
            .entry       (entry_w[g]),
            .lt          (lt_w[g]),
            .first       (first_w[g])
         );
      end
   endgenerate

   always_comb begin
      busy_in      = busy_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      occ_in       = occ_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         busy_in = 1'b1;
         cmd_in  = req_tdata[CMD_W-1:0];
         key_in  = req_tdata[CMD_W +: VALUE_W];
      end

      if (exec) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         pos_in       = '0;
         unique case (cmd_ff)
            CMD_INSERT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_INSERTED;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            CMD_DELETE: begin
               if (found) begin
                  status_in = ST_DELETED;
                  count_in  = count_ff - CNT_W'(1);
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
            CMD_FIND: begin
               if (found) begin
                  status_in = ST_FOUND;
                  pos_in    = POS_W'(match_pos);
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
            default: begin
               status_in = ST_NOT_FOUND;
            end
         endcase
         occ_in = POS_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      occ_ff    <= occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({occ_ff, pos_ff, status_ff});

endmodule

[src/slt_cell.sv]
`timescale 1ns / 1ps
module slt_cell
   import slt_pkg::*;
(
   input  logic               clock,
   input  slt_op_type         op,
   input  logic [VALUE_W-1:0] key,
   input  logic               valid,
   input  logic               left_lt,
   input  logic [VALUE_W-1:0] left_entry,
   input  logic [VALUE_W-1:0] right_entry,
   output logic [VALUE_W-1:0] entry,
   output logic               lt,
   output logic               first
);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               eq;

   assign lt    = valid && ($signed(entry_ff) < $signed(key));
   assign eq    = valid && (entry_ff == key);
   // The list is ascending, so the first equal entry is the one whose left
   // neighbor is still smaller than the key.
   assign first = eq && left_lt;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (op.ins) begin
         if (lt) begin
            entry_in = entry_ff;
         end else if (left_lt) begin
            entry_in = key;
         end else begin
            entry_in = left_entry;
         end
      end else if (op.del && !lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[src/slt_checker.sv]
`timescale 1ns / 1ps
module slt_checker
   import slt_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    position;
   logic [POS_W-1:0]    occupancy;

   assign status     = rsp_tdata[STATUS_W-1:0];
   assign position   = rsp_tdata[STATUS_W +: POS_W];
   assign occupancy  = rsp_tdata[STATUS_W+POS_W +: POS_W];

   // A response held back by the receiver stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   // One item is held at a time: taking a request closes the request side.
   a_one_held: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is held");

   // A refused insert only happens on a full list.
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == ST_FULL) |-> occupancy == POS_W'(CAPACITY))
      else $error("insert refused below capacity");

   // A nonzero position only comes with a successful find inside the list.
   a_pos_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (position != '0) |->
         (status == ST_FOUND) && ((CAPACITY > 63) || (position <= occupancy)))
      else $error("position reported without a match in the list");

endmodule

bind sorted_list_table slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the sorted list table. Request and response streams
// are driven on the falling edge and sampled on the rising edge. A small
// scoreboard keeps its own copy of the sorted list, works out the response of
// every accepted request item, and checks responses in order.
module testbench;
   import slt_pkg::*;

   localparam int LIST_CAPACITY = DEF_CAPACITY;
   localparam int RANDOM_ITEMS  = 1100;
   // Cycles in which no item moves on either stream before the run is aborted.
   localparam int IDLE_LIMIT    = 2000;
   // Quiet cycles after the last response, enough to catch a stray response.
   localparam int DRAIN_CYCLES  = 20;

   // Command code 3 is not defined; the block must treat it as a miss.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Command mix of one round of random stimulus.
   typedef enum int {MIX_FILL, MIX_GROW, MIX_DRAIN, MIX_BALANCED} mix_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [POS_W-1:0]    occupancy;
   } list_result_type;

   // Keeps the expected list contents and the responses still owed by the block.
   class list_scoreboard_type;
      logic signed [VALUE_W-1:0] contents[$];
      list_result_type           expected_q[$];
      int                        errors = 0;

      function int pending();
         return expected_q.size();
      endfunction

      task report(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Applies one accepted request to the list copy and queues its response.
      function void note_request(input logic [CMD_W-1:0] cmd,
                                 input logic signed [VALUE_W-1:0] value);
         list_result_type res;
         int              slot;
         res.status   = ST_NOT_FOUND;
         res.position = '0;
         slot = 0;
         case (cmd)
            CMD_INSERT: begin
               if (contents.size() >= LIST_CAPACITY) begin
                  res.status = ST_FULL;
               end else begin
                  // The new value goes ahead of any equal entry.
                  while (slot < contents.size() && value > contents[slot]) slot++;
                  contents.insert(slot, value);
                  res.status = ST_INSERTED;
               end
            end
            CMD_DELETE, CMD_FIND: begin
               while (slot < contents.size() && contents[slot] != value) slot++;
               if (slot < contents.size()) begin
                  if (cmd == CMD_DELETE) begin
                     contents.delete(slot);
                     res.status = ST_DELETED;
                  end else begin
                     res.status   = ST_FOUND;
                     res.position = POS_W'(slot + 1);
                  end
               end
            end
            default: begin
            end
         endcase
         res.occupancy = POS_W'(contents.size());
         expected_q.push_back(res);
      endfunction

      task check_response(input logic [RSP_DATA_W-1:0] data);
         list_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("response %h with no request outstanding", data));
         end else begin
            want = expected_q.pop_front();
            if (data[2:0] !== want.status)
               report($sformatf("status %0d, expected %0d", data[2:0], want.status));
            if (data[8:3] !== want.position)
               report($sformatf("position %0d, expected %0d", data[8:3], want.position));
            if (data[14:9] !== want.occupancy)
               report($sformatf("occupancy %0d, expected %0d",
                                data[14:9], want.occupancy));
         end
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [1:0] command, [33:2] value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [2:0] status, [8:3] position,
                                             // [14:9] occupancy

   list_scoreboard_type scoreboard;
   int                  random_items = 0;
   logic                stalls_on    = 1'b0;
   int                  idle_cycles  = 0;

   sorted_list_table #(.CAPACITY(LIST_CAPACITY)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Monitor: at every rising edge the response is checked before the request
   // is noted, so a response can never be matched with a request accepted at
   // the same edge. The watchdog counts edges at which no item moves.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) scoreboard.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            scoreboard.note_request(req_tdata[1:0], req_tdata[33:2]);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: alternates runs of ready cycles with stall runs of random
   // length. With stalls switched off it accepts every response at once.
   always @(negedge clock) begin
      int ready_left;
      int stall_left;
      if (ready_left != 0) begin
         rsp_tready <= 1'b1;
         ready_left--;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         ready_left = $urandom_range(0, 12);
         stall_left = stalls_on ? $urandom_range(1, 8) : 0;
      end
   end

   // Offers one request item and returns at the falling edge after it was
   // taken, with valid still high so that a back-to-back item follows cleanly.
   task automatic send_item(input logic [CMD_W-1:0] cmd,
                            input logic [VALUE_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({value, cmd});
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Values for random items. Delete and find mostly name a stored entry so
   // that they hit; the rest mixes a narrow band around zero (for duplicates),
   // the extremes of the signed range, zero and minus one, and fully random patterns.
   function automatic logic [VALUE_W-1:0] pick_value(input bit prefer_stored);
      int unsigned roll;
      int          held;
      roll = $urandom_range(0, 99);
      held = scoreboard.contents.size();
      if (held != 0 && roll < (prefer_stored ? 60 : 20))
         return scoreboard.contents[$urandom_range(0, held - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 30) return VALUE_W'($urandom_range(0, 8)) - 32'd4;
      if (roll < 40) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom();
   endfunction

   task automatic send_random(input mix_type mix);
      logic [CMD_W-1:0] cmd;
      int unsigned      roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  cmd = CMD_INSERT;
         MIX_GROW:  cmd = roll < 65 ? CMD_INSERT : roll < 80 ? CMD_DELETE :
                          roll < 97 ? CMD_FIND : CMD_UNUSED;
         MIX_DRAIN: cmd = roll < 20 ? CMD_INSERT : roll < 70 ? CMD_DELETE :
                          roll < 97 ? CMD_FIND : CMD_UNUSED;
         default:   cmd = roll < 40 ? CMD_INSERT : roll < 70 ? CMD_DELETE :
                          roll < 97 ? CMD_FIND : CMD_UNUSED;
      endcase
      send_item(cmd, pick_value(cmd != CMD_INSERT));
      if (cmd != CMD_UNUSED) random_items++;
   endtask

   initial begin
      mix_type mix;
      int      round_left;
      int      burst_left;
      bit      gaps_on;
      bit      first_round;

      scoreboard = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: commands on an empty list, the unused command code,
      // both ends of the signed range, duplicates, and hits and misses.
      send_item(CMD_FIND,   32'h0000_0000);
      send_item(CMD_DELETE, 32'h0000_0000);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'h7FFF_FFFF);
      send_item(CMD_INSERT, 32'h8000_0000);
      send_item(CMD_INSERT, 32'h0000_0000);
      send_item(CMD_INSERT, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'h0000_0001);
      send_item(CMD_INSERT, 32'h0000_0005);
      send_item(CMD_INSERT, 32'h0000_0005);
      send_item(CMD_FIND,   32'h8000_0000);
      send_item(CMD_FIND,   32'h7FFF_FFFF);
      send_item(CMD_FIND,   32'h0000_0005);
      send_item(CMD_FIND,   32'h0000_0006);
      send_item(CMD_UNUSED, 32'hAAAA_AAAA);
      send_item(CMD_DELETE, 32'h0000_0005);
      send_item(CMD_FIND,   32'h0000_0005);
      send_item(CMD_DELETE, 32'h0000_0005);
      send_item(CMD_DELETE, 32'h0000_0005);
      send_item(CMD_DELETE, 32'h8000_0000);
      send_item(CMD_DELETE, 32'h7FFF_FFFF);
      send_item(CMD_FIND,   32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'h5555_5555);

      // Random part in rounds. The first round only inserts, so the list is
      // sure to fill and the refusal of a full list is exercised early. Each
      // round draws its own command mix, idle gaps and receiver stalls.
      first_round = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         mix        = first_round ? MIX_FILL : mix_type'($urandom_range(MIX_GROW,
                                                                        MIX_BALANCED));
         round_left = first_round ? LIST_CAPACITY + 8 : $urandom_range(40, 120);
         gaps_on    = $urandom_range(0, 3) != 0;
         stalls_on  = $urandom_range(0, 3) != 0;
         burst_left = $urandom_range(1, 16);
         while (round_left > 0) begin
            send_random(mix);
            round_left--;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if (gaps_on) pause_sender($urandom_range(1, 6));
            end
         end
         // Hold the sender back until every owed response has arrived, so the
         // block also runs from a fully idle state. Always done once.
         if (first_round || $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            while (scoreboard.pending() != 0) @(negedge clock);
         end
         first_round = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (scoreboard.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
src/slt_pkg.sv
src/slt_cell.sv
src/sorted_list_table.sv
src/slt_checker.sv
verif/testbench.sv
